### design/keepalive_link_watchdog_unit_assert.svh
// Assertion helpers for the keepalive link watchdog.
`ifndef KEEPALIVE_LINK_WATCHDOG_UNIT_ASSERT_SVH
`define KEEPALIVE_LINK_WATCHDOG_UNIT_ASSERT_SVH

// Checked on the rising clock, skipped while reset is asserted.
`define KLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on the rising clock at all times, reset included.
`define KLW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/klw_pkg.sv
package klw_pkg;

  localparam int unsigned SeqPortW   = 32;
  localparam int unsigned TimerW     = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [TimerW-1:0] TxIntervalRst = 16'd3;
  localparam logic [TimerW-1:0] RxTimeoutRst  = 16'd10;
  localparam logic [CountW-1:0] StallLimitRst = 8'd10;

  typedef enum logic [2:0] {
    KIND_TICK         = 3'd0,
    KIND_KEEPALIVE    = 3'd1,
    KIND_LOCAL_START  = 3'd2,
    KIND_REMOTE_START = 3'd3,
    KIND_RECOVERED    = 3'd4
  } klw_kind_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_STALL = 2'd1,
    ST_BUSY  = 2'd2,
    ST_LIMIT = 2'd3
  } klw_status_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_TX_INTERVAL = 2'd0,
    REG_RX_TIMEOUT  = 2'd1,
    REG_STALL_LIMIT = 2'd2
  } klw_reg_e;

  typedef struct packed {
    logic [TimerW-1:0] tx_interval;
    logic [TimerW-1:0] rx_timeout;
    logic [CountW-1:0] stall_limit;
  } klw_cfg_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [SeqPortW-1:0] recv_seq;
    logic [SeqPortW-1:0] wait_seq;
    logic                peer_busy;
  } klw_item_t;

endpackage

### design/keepalive_link_watchdog_unit.sv
// Keepalive link watchdog: each input beat is one event (tick, keepalive
// received, local start, remote start, recovery done) and yields exactly one
// result beat with the keepalive-send and recover requests, a status code and
// the current stall count. Throughput is one beat per clock while the result
// side is not stalled; a beat passes through the input register and then the
// result register around the combinational event logic. The input side stalls
// only when its register is full and the result register is held by the
// consumer. Sequence numbers are compared on their low SEQ_WIDTH bits (at
// most the 32 port bits). Configuration writes are always ready and must be
// issued only while no beat is in flight.
`include "keepalive_link_watchdog_unit_assert.svh"

module keepalive_link_watchdog_unit import klw_pkg::*; #(
  parameter int unsigned SEQ_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // event input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           kind_i,
  input  logic [SeqPortW-1:0]  recv_seq_i,
  input  logic [SeqPortW-1:0]  wait_seq_i,
  input  logic                 peer_busy_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 send_keepalive_o,
  output logic                 request_recover_o,
  output logic [1:0]           event_status_o,
  output logic [CountW-1:0]    stall_count_o
);

  klw_cfg_t  cfg;
  klw_item_t item_in, item_q;
  logic      item_vld;
  logic      take;

  // gather the input beat into one word
  assign item_in.kind      = kind_i;
  assign item_in.recv_seq  = recv_seq_i;
  assign item_in.wait_seq  = wait_seq_i;
  assign item_in.peer_busy = peer_busy_i;

  klw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register: parts the producer from the result stall
  klw_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .take_i     (take),
    .vld_o      (item_vld),
    .item_o     (item_q)
  );

  // event logic, watchdog state and result register
  klw_core #(
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .vld_i             (item_vld),
    .item_i            (item_q),
    .take_o            (take),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .send_keepalive_o  (send_keepalive_o),
    .request_recover_o (request_recover_o),
    .event_status_o    (event_status_o),
    .stall_count_o     (stall_count_o)
  );

  // A tick either expires the receive timer or may send a keepalive, never both.
  `KLW_ASSERT(a_send_xor_recover,
              out_valid_o |-> !(send_keepalive_o && request_recover_o),
              "send and recover together")
  // Limit status only when the count has reached the programmed limit.
  `KLW_ASSERT(a_limit_count,
              (out_valid_o && event_status_o == ST_LIMIT) |-> (stall_count_o >= cfg.stall_limit),
              "limit status below limit")
  // A recover request comes from a tick, which never carries a keepalive status.
  `KLW_ASSERT(a_recover_status,
              (out_valid_o && request_recover_o) |-> (event_status_o == ST_NONE),
              "recover with status")

endmodule

### design/klw_cfg_regs.sv
module klw_cfg_regs import klw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output klw_cfg_t             cfg_o
);

  klw_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (klw_reg_e'(cfg_index_i))
        REG_TX_INTERVAL: cfg_d.tx_interval = cfg_data_i;
        REG_RX_TIMEOUT:  cfg_d.rx_timeout  = cfg_data_i;
        REG_STALL_LIMIT: cfg_d.stall_limit = cfg_data_i[CountW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tx_interval <= TxIntervalRst;
      cfg_q.rx_timeout  <= RxTimeoutRst;
      cfg_q.stall_limit <= StallLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/klw_in_reg.sv
module klw_in_reg import klw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  klw_item_t item_i,
  input  logic      take_i,
  output logic      vld_o,
  output klw_item_t item_o
);

  logic      vld_q, vld_d;
  logic      accept;
  klw_item_t item_q;

  // hold while occupied and not drained this cycle
  assign in_stall_o = vld_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign vld_d      = accept || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

### design/klw_core.sv
module klw_core import klw_pkg::*; #(
  parameter int unsigned SEQ_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  klw_cfg_t          cfg_i,
  input  logic              vld_i,
  input  klw_item_t         item_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              send_keepalive_o,
  output logic              request_recover_o,
  output logic [1:0]        event_status_o,
  output logic [CountW-1:0] stall_count_o
);

  localparam int unsigned CmpW = (SEQ_WIDTH < SeqPortW) ? SEQ_WIDTH : SeqPortW;

  logic [TimerW-1:0] rx_timer_q, rx_timer_d;
  logic [TimerW-1:0] tx_timer_q, tx_timer_d;
  logic              recovering_q, recovering_d;
  logic [CmpW-1:0]   saved_seq_q, saved_seq_d;
  logic [CountW-1:0] stall_cnt_q, stall_cnt_d;

  logic              out_vld_q, out_vld_d;
  logic              send_q, send_d;
  logic              recover_q, recover_d;
  klw_status_e       status_q, status_d;

  logic [CmpW-1:0]   rseq, wseq;
  logic [TimerW-1:0] rx_dec, tx_dec;

  assign take_o    = vld_i && (!out_vld_q || !out_stall_i);
  assign out_vld_d = take_o || (out_vld_q && out_stall_i);

  assign rseq   = item_i.recv_seq[CmpW-1:0];
  assign wseq   = item_i.wait_seq[CmpW-1:0];
  assign rx_dec = (rx_timer_q != '0) ? rx_timer_q - 1'b1 : rx_timer_q;
  assign tx_dec = tx_timer_q - 1'b1;

  always_comb begin
    rx_timer_d   = rx_timer_q;
    tx_timer_d   = tx_timer_q;
    recovering_d = recovering_q;
    saved_seq_d  = saved_seq_q;
    stall_cnt_d  = stall_cnt_q;
    send_d       = 1'b0;
    recover_d    = 1'b0;
    status_d     = ST_NONE;
    unique case (klw_kind_e'(item_i.kind))
      KIND_TICK: begin
        if (!recovering_q) begin
          rx_timer_d = rx_dec;
          if (rx_dec == '0) begin
            recovering_d = 1'b1;
            recover_d    = 1'b1;
          end else if (tx_dec == '0) begin
            send_d     = 1'b1;
            tx_timer_d = cfg_i.tx_interval;
          end else begin
            tx_timer_d = tx_dec;
          end
        end
      end
      KIND_KEEPALIVE: begin
        if (rseq != saved_seq_q) begin
          saved_seq_d = rseq;
          stall_cnt_d = '0;
        end else if (rseq < wseq) begin
          if (item_i.peer_busy) begin
            stall_cnt_d = '0;
            status_d    = ST_BUSY;
          end else begin
            stall_cnt_d = (stall_cnt_q == '1) ? stall_cnt_q : stall_cnt_q + 1'b1;
            status_d    = ST_STALL;
          end
        end
        if (stall_cnt_d < cfg_i.stall_limit) begin
          rx_timer_d = cfg_i.rx_timeout;
        end else begin
          rx_timer_d = '0;
          status_d   = ST_LIMIT;
        end
      end
      KIND_LOCAL_START:  tx_timer_d   = cfg_i.tx_interval;
      KIND_REMOTE_START: rx_timer_d   = cfg_i.rx_timeout;
      KIND_RECOVERED:    recovering_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_timer_q   <= '0;
      tx_timer_q   <= TxIntervalRst;
      recovering_q <= 1'b0;
      saved_seq_q  <= '0;
      stall_cnt_q  <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (take_o) begin
        rx_timer_q   <= rx_timer_d;
        tx_timer_q   <= tx_timer_d;
        recovering_q <= recovering_d;
        saved_seq_q  <= saved_seq_d;
        stall_cnt_q  <= stall_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      send_q    <= send_d;
      recover_q <= recover_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign send_keepalive_o  = send_q;
  assign request_recover_o = recover_q;
  assign event_status_o    = status_q;
  // counter only moves on a take, so it matches the held result
  assign stall_count_o     = stall_cnt_q;

endmodule

### tb/sv/klw_checker.sv
module klw_checker import klw_pkg::*; #(
  parameter int unsigned SEQ_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [2:0]           kind_i,
  input  logic [SeqPortW-1:0]  recv_seq_i,
  input  logic [SeqPortW-1:0]  wait_seq_i,
  input  logic                 peer_busy_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 send_keepalive_i,
  input  logic                 request_recover_i,
  input  logic [1:0]           event_status_i,
  input  logic [CountW-1:0]    stall_count_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam logic [SeqPortW-1:0] SeqMask = (SEQ_WIDTH >= SeqPortW) ? {SeqPortW{1'b1}} :
                                            SeqPortW'((64'd1 << SEQ_WIDTH) - 64'd1);

  typedef struct packed {
    logic              send;
    logic              recover;
    klw_status_e       status;
    logic [CountW-1:0] count;
  } link_result_t;

  klw_cfg_t            cfg_q;
  logic [TimerW-1:0]   rx_left;
  logic [TimerW-1:0]   tx_left;
  logic                recovering;
  logic [SeqPortW-1:0] last_recv_seq;
  logic [CountW-1:0]   stalls;
  link_result_t        expected_results [$];
  int unsigned         fails;

  // Advance the watchdog copy by one event and return the result it gives.
  function automatic link_result_t advance_link(input klw_item_t ev);
    link_result_t        res;
    logic [SeqPortW-1:0] rseq;
    logic [SeqPortW-1:0] wseq;
    res  = '0;
    rseq = ev.recv_seq & SeqMask;
    wseq = ev.wait_seq & SeqMask;
    case (ev.kind)
      KIND_TICK: begin
        if (!recovering) begin
          if (rx_left != '0) rx_left = rx_left - 1'b1;
          if (rx_left == '0) begin
            recovering  = 1'b1;
            res.recover = 1'b1;
          end else begin
            tx_left = tx_left - 1'b1;
            if (tx_left == '0) begin
              res.send = 1'b1;
              tx_left  = cfg_q.tx_interval;
            end
          end
        end
      end
      KIND_KEEPALIVE: begin
        if (rseq != last_recv_seq) begin
          last_recv_seq = rseq;
          stalls        = '0;
        end else if (rseq < wseq) begin
          if (ev.peer_busy) begin
            stalls     = '0;
            res.status = ST_BUSY;
          end else begin
            if (stalls != {CountW{1'b1}}) stalls = stalls + 1'b1;
            res.status = ST_STALL;
          end
        end
        if (stalls < cfg_q.stall_limit) begin
          rx_left = cfg_q.rx_timeout;
        end else begin
          rx_left    = '0;
          res.status = ST_LIMIT;
        end
      end
      KIND_LOCAL_START:  tx_left = cfg_q.tx_interval;
      KIND_REMOTE_START: rx_left = cfg_q.rx_timeout;
      KIND_RECOVERED:    recovering = 1'b0;
      default: ;
    endcase
    res.count = stalls;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    link_result_t want;
    link_result_t got;
    if (!rst_ni) begin
      cfg_q         = '{tx_interval: TxIntervalRst, rx_timeout: RxTimeoutRst,
                        stall_limit: StallLimitRst};
      rx_left       = '0;
      tx_left       = TxIntervalRst;
      recovering    = 1'b0;
      last_recv_seq = '0;
      stalls        = '0;
      fails         = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TX_INTERVAL: cfg_q.tx_interval = cfg_data_i;
          REG_RX_TIMEOUT:  cfg_q.rx_timeout  = cfg_data_i;
          REG_STALL_LIMIT: cfg_q.stall_limit = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got = '{send: send_keepalive_i, recover: request_recover_i,
                status: klw_status_e'(event_status_i), count: stall_count_i};
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result beat send=%0b recover=%0b status=%0d count=%0d",
                     $realtime, got.send, got.recover, got.status, got.count);
        end else begin
          want = expected_results.pop_front();
          if (got.send !== want.send || got.recover !== want.recover ||
              got.status !== want.status || got.count !== want.count) begin
            fails++;
            if (fails <= 10) begin
              $write("%0t: result mismatch, expected send=%0b recover=%0b status=%0d count=%0d",
                     $realtime, want.send, want.recover, want.status, want.count);
              $display(", got send=%0b recover=%0b status=%0d count=%0d",
                       got.send, got.recover, got.status, got.count);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i)
        expected_results.push_back(advance_link('{kind: kind_i, recv_seq: recv_seq_i,
                                                  wait_seq: wait_seq_i,
                                                  peer_busy: peer_busy_i}));

      fail_count_o <= fails;
      pending_o    <= expected_results.size();
    end
  end

endmodule

### tb/sv/tb.sv
module tb;
  import klw_pkg::*;

  localparam int unsigned SeqW = 32;

  // Clock and reset: reset is held low from time zero and released once.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration write channel.
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  // Event channel into the watchdog.
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           kind_i      = '0;
  logic [SeqPortW-1:0]  recv_seq_i  = '0;
  logic [SeqPortW-1:0]  wait_seq_i  = '0;
  logic                 peer_busy_i = 1'b0;

  // Result channel out of the watchdog.
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 send_keepalive_o;
  logic                 request_recover_o;
  logic [1:0]           event_status_o;
  logic [CountW-1:0]    stall_count_o;

  int unsigned          fail_count;
  int unsigned          pending;

  // When set, the sender offers beats back to back with no gaps.
  bit                   steady    = 1'b0;
  // Cycles left before the result side picks a new stall pattern.
  int unsigned          back_hold = 0;
  // Sequence number the simulated peer currently reports as received.
  logic [SeqPortW-1:0]  link_seq  = '0;

  always #4 clk_i = ~clk_i;

  keepalive_link_watchdog_unit #(.SEQ_WIDTH(SeqW)) u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .recv_seq_i,
    .wait_seq_i,
    .peer_busy_i,
    .out_valid_o,
    .out_stall_i,
    .send_keepalive_o,
    .request_recover_o,
    .event_status_o,
    .stall_count_o
  );

  klw_checker #(.SEQ_WIDTH(SeqW)) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i        (in_stall_o),
    .kind_i,
    .recv_seq_i,
    .wait_seq_i,
    .peer_busy_i,
    .out_valid_i       (out_valid_o),
    .out_stall_i,
    .send_keepalive_i  (send_keepalive_o),
    .request_recover_i (request_recover_o),
    .event_status_i    (event_status_o),
    .stall_count_i     (stall_count_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Hard stop: far beyond the slowest legal run, even with every beat
  // hitting the longest sender gap and the longest result stall.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side back-pressure: mostly short bursts of stall, now and then a
  // long hold, and long stretches with no stall at all.
  always @(posedge clk_i) begin
    int unsigned pick;
    if (back_hold != 0) begin
      back_hold <= back_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_stall_i <= 1'b0;
        back_hold   <= $urandom_range(0, 5);
      end else if (pick < 80) begin
        out_stall_i <= 1'b1;
        back_hold   <= $urandom_range(0, 2);
      end else if (pick < 92) begin
        out_stall_i <= 1'b0;
        back_hold   <= $urandom_range(30, 120);
      end else begin
        out_stall_i <= 1'b1;
        back_hold   <= $urandom_range(15, 50);
      end
    end
  end

  function automatic klw_item_t beat_of(input logic [2:0] k, input logic [SeqPortW-1:0] r,
                                        input logic [SeqPortW-1:0] w, input logic b);
    return '{kind: k, recv_seq: r, wait_seq: w, peer_busy: b};
  endfunction

  // Idle cycles before the next beat: mostly none or a few, rarely a long gap.
  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Draw the next event of a plausible link session. Keepalives mostly repeat
  // the peer's sequence so the stall count climbs; now and then the sequence
  // moves on, the peer goes busy, or the fields are plain noise.
  function automatic klw_item_t next_event();
    klw_item_t   ev;
    int unsigned pick;
    ev.recv_seq  = $urandom();
    ev.wait_seq  = $urandom();
    ev.peer_busy = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      ev.kind = KIND_TICK;
    end else if (pick < 75) begin
      ev.kind = KIND_KEEPALIVE;
      pick = $urandom_range(0, 99);
      if (pick < 12) link_seq = link_seq + 1'b1;
      else if (pick < 20) link_seq = $urandom();
      ev.recv_seq = link_seq;
      pick = $urandom_range(0, 99);
      if (pick < 60) ev.wait_seq = link_seq + $urandom_range(1, 4);
      else if (pick < 85) ev.wait_seq = link_seq;
      ev.peer_busy = ($urandom_range(0, 99) < 15);
    end else if (pick < 83) begin
      ev.kind = KIND_RECOVERED;
    end else if (pick < 90) begin
      ev.kind = KIND_REMOTE_START;
    end else if (pick < 95) begin
      ev.kind = KIND_LOCAL_START;
    end else begin
      // kinds outside the defined set must be ignored
      ev.kind = 3'($urandom_range(5, 7));
    end
    return ev;
  endfunction

  // Offer one beat and hold it until accepted. Called at a rising edge and
  // returns at the edge that took the beat; valid stays high between
  // back-to-back beats so it is never dropped and raised in one step.
  task automatic push_event(input klw_item_t ev);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= ev.kind;
    recv_seq_i  <= ev.recv_seq;
    wait_seq_i  <= ev.wait_seq;
    peer_busy_i <= ev.peer_busy;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait for every outstanding result. The first edge lets
  // the checker's count catch up with the beat taken at the calling edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write all three registers; only called with nothing in flight.
  task automatic program_watchdog(input logic [TimerW-1:0] tx, input logic [TimerW-1:0] rx,
                                  input logic [CountW-1:0] lim);
    klw_reg_e            order [3];
    logic [CfgDataW-1:0] value [3];
    order = '{REG_TX_INTERVAL, REG_RX_TIMEOUT, REG_STALL_LIMIT};
    value = '{tx, rx, CfgDataW'(lim)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= value[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    klw_item_t         ev;
    klw_item_t         opening [$];
    logic [TimerW-1:0] tx_pick  [5] = '{16'd1, 16'd65535, 16'd2, 16'd5, 16'd3};
    logic [TimerW-1:0] rx_pick  [5] = '{16'd1, 16'd65535, 16'd6, 16'd20, 16'd40};
    logic [CountW-1:0] lim_pick [5] = '{8'd1, 8'd255, 8'd3, 8'd8, 8'd255};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at reset settings (interval 3, timeout 10, limit 10).
    opening = '{
      // first tick after reset: receive timer is already zero, recover at once
      beat_of(KIND_TICK, '0, '0, 1'b0),
      // tick while recovering does nothing
      beat_of(KIND_TICK, '0, '0, 1'b0),
      // keepalive while recovering, same sequence and not behind
      beat_of(KIND_KEEPALIVE, '0, '0, 1'b0),
      beat_of(KIND_RECOVERED, '0, '0, 1'b0),
      beat_of(KIND_LOCAL_START, '0, '0, 1'b0),
      beat_of(KIND_REMOTE_START, '0, '0, 1'b0),
      // third tick after the start sends a keepalive
      beat_of(KIND_TICK, '0, '0, 1'b0),
      beat_of(KIND_TICK, '0, '0, 1'b0),
      beat_of(KIND_TICK, '0, '0, 1'b0),
      // new sequence at the top of the range
      beat_of(KIND_KEEPALIVE, '1, '0, 1'b1),
      beat_of(KIND_KEEPALIVE, '1, '1, 1'b0),
      // back to zero, then stall, busy clear, stall again
      beat_of(KIND_KEEPALIVE, '0, '0, 1'b1),
      beat_of(KIND_KEEPALIVE, '0, '1, 1'b0),
      beat_of(KIND_KEEPALIVE, '0, '1, 1'b1),
      beat_of(KIND_KEEPALIVE, '0, 32'd1, 1'b0),
      // undefined kinds with noisy fields
      beat_of(3'd5, $urandom(), $urandom(), 1'b1),
      beat_of(3'd6, $urandom(), $urandom(), 1'b0),
      beat_of(3'd7, $urandom(), $urandom(), 1'b1),
      beat_of(KIND_TICK, '0, '0, 1'b0)
    };
    foreach (opening[i]) push_event(opening[i]);

    // Random phases, each under its own register settings; the extremes
    // come first, the later phases draw small values so limits are hit.
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      if (phase < 5)
        program_watchdog(tx_pick[phase], rx_pick[phase], lim_pick[phase]);
      else
        program_watchdog(TimerW'($urandom_range(1, 8)), TimerW'($urandom_range(2, 30)),
                         CountW'($urandom_range(1, 12)));
      steady = (phase % 3 == 2);

      // With the limit at its top, run a long stalled stream so the count
      // reaches the limit and then saturates.
      if (phase == 4) begin
        link_seq = link_seq + 1'b1;
        ev = beat_of(KIND_KEEPALIVE, link_seq, link_seq + 32'd9, 1'b0);
        repeat (260) push_event(ev);
      end

      for (int n = 0; n < 110; n++) begin
        push_event(next_event());
        // hold off mid-phase until the pipe is empty
        if (phase == 3 && n == 55) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/klw_pkg.sv
design/klw_cfg_regs.sv
design/klw_in_reg.sv
design/klw_core.sv
design/keepalive_link_watchdog_unit.sv
tb/sv/klw_checker.sv
tb/sv/tb.sv
